### sv/flbt_pkg.sv
package flbt_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 8;
  localparam int TIME_W  = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'b1;

  localparam logic [COUNT_W-1:0] THRESHOLD_RST = 8'd5;
  localparam logic [TIME_W-1:0]  WINDOW_RST    = 32'd3600;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_BLOCK   = 2'd1,
    ACT_UNBLOCK = 2'd2
  } action_e;

  typedef enum logic {
    CMD_FAIL    = 1'b0,
    CMD_SUCCESS = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_e;

  // one table slot as stored in the memory
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  last_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### sv/failed_login_block_table.sv
// m_axis_tvalid is registered: a whitelisted event goes from acceptance through ST_RESP; any other
// event scans the slot memory one entry a cycle (one read port) in ST_SCAN, then passes ST_UPDATE
// and ST_RESP before the result is registered; a stalled output holds the event in ST_RESP.
// throughput: one event at a time; the next is taken once the result is registered, later while
// the result sits stalled.
// reset: config registers return to threshold 5 and window 3600; a clearing pass then zeroes
// all TABLE_ENTRIES slots, one per cycle, with s_axis_tready low for those cycles.
module failed_login_block_table
  import flbt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // events
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,   // ip_address[31:0], now_seconds[63:32]
  input  logic [1:0]            s_axis_tuser,   // cmd[0], on_whitelist[1]
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata    // action[1:0], add_whitelist[2], zero[7:3]
);

  localparam int AW   = $clog2(TABLE_ENTRIES);
  localparam int CNTW = AW + 1;

  state_e state_q, state_d;

  logic [COUNT_W-1:0] thr_q;
  logic [TIME_W-1:0]  win_q;

  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic [CNTW-1:0] rd_cnt_q, rd_cnt_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]   ptr_q, ptr_d, ptr_next;
  logic            hit_q, hit_d;
  logic [AW-1:0]   hit_idx_q, hit_idx_d;
  entry_t          ent_q, ent_d;

  // event payload
  cmd_e              cmd_q, cmd_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [TIME_W-1:0] now_q, now_d;

  action_e res_act_q, res_act_d;
  logic    res_wl_q, res_wl_d;

  logic       m_valid_q, m_valid_d;
  logic [7:0] m_data_q, m_data_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic               in_fire;
  logic [TIME_W-1:0]  elapsed;
  logic [COUNT_W-1:0] base_cnt, inc_cnt;

  flbt_ram #(
    .Width(ENTRY_W),
    .Depth(TABLE_ENTRIES)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign ptr_next = (ptr_q == AW'(TABLE_ENTRIES - 1)) ? '0 : ptr_q + 1'b1;

  // failure update arithmetic, from the captured slot
  assign elapsed  = now_q - ent_q.last_time;
  assign base_cnt = (hit_q && (elapsed <= win_q)) ? ent_q.count : '0;
  assign inc_cnt  = base_cnt + 1'b1;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    rd_cnt_d  = rd_cnt_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    ptr_d     = ptr_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    ent_d     = ent_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    now_d     = now_q;
    res_act_d = res_act_q;
    res_wl_d  = res_wl_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = rd_cnt_q[AW-1:0];

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(TABLE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          cmd_d     = cmd_e'(s_axis_tuser[0]);
          addr_d    = s_axis_tdata[31:0];
          now_d     = s_axis_tdata[63:32];
          rd_cnt_d  = '0;
          cmp_vld_d = 1'b0;
          if (s_axis_tuser[1]) begin
            res_act_d = ACT_NONE;
            res_wl_d  = 1'b0;
            state_d   = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // compare the entry read last cycle; on no hit the next read goes out while entries remain
        if (cmp_vld_q && (ram_rdata.address == addr_q)) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          ent_d     = ram_rdata;
          cmp_vld_d = 1'b0;
          state_d   = ST_UPDATE;
        end else if (rd_cnt_q == CNTW'(TABLE_ENTRIES)) begin
          hit_d     = 1'b0;
          cmp_vld_d = 1'b0;
          state_d   = ST_UPDATE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = rd_cnt_q[AW-1:0];
          cmp_idx_d = rd_cnt_q[AW-1:0];
          cmp_vld_d = 1'b1;
          rd_cnt_d  = rd_cnt_q + 1'b1;
        end
      end

      ST_UPDATE: begin
        state_d = ST_RESP;
        if (cmd_q == CMD_FAIL) begin
          res_wl_d          = 1'b0;
          ram_we            = 1'b1;
          ram_waddr         = hit_q ? hit_idx_q : ptr_next;
          ram_wdata.address = addr_q;
          if (!hit_q) begin
            ptr_d = ptr_next;
          end
          if ((base_cnt <= thr_q) && (base_cnt != COUNT_MAX)) begin
            ram_wdata.count     = inc_cnt;
            ram_wdata.last_time = now_q;
            res_act_d           = (inc_cnt >= thr_q) ? ACT_BLOCK : ACT_NONE;
          end else begin
            ram_wdata.count     = base_cnt;
            ram_wdata.last_time = ent_q.last_time;
            res_act_d           = ACT_NONE;
          end
        end else begin
          res_wl_d  = 1'b1;
          res_act_d = ACT_NONE;
          if (hit_q) begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx_q;
            ram_wdata = '0;
            if (ent_q.count >= thr_q) begin
              res_act_d = ACT_UNBLOCK;
            end
          end
        end
      end

      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'd0, res_wl_q, res_act_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      ptr_q     <= '0;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      rd_cnt_q  <= rd_cnt_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
      ptr_q     <= ptr_d;
      hit_q     <= hit_d;
      hit_idx_q <= hit_idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q     <= ent_d;
    cmd_q     <= cmd_d;
    addr_q    <= addr_d;
    now_q     <= now_d;
    res_act_q <= res_act_d;
    res_wl_q  <= res_wl_d;
    m_data_q  <= m_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      win_q <= WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: thr_q <= cfg_wdata_i[COUNT_W-1:0];
        CFG_WINDOW:    win_q <= cfg_wdata_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // no event is taken while the slot memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("event accepted during clearing pass");

  // the memory is written only by the clearing pass or the update step
  a_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_CLEAR) || (state_q == ST_UPDATE)))
    else $error("slot memory written outside clear or update");

  // an update always hands over to the result stage next
  a_update_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> (state_q == ST_RESP))
    else $error("update not followed by result stage");

  // a whitelist request never comes with a block, and action code 2'b11 never appears
  a_result_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[1:0] != 2'b11) &&
                       !(m_axis_tdata[2] && (m_axis_tdata[1:0] == ACT_BLOCK))))
    else $error("invalid result code");

endmodule

### sv/flbt_ram.sv
module flbt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
